// ===== rtl/rgbcc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the RGB color classifier: item types, register indexes and
// fixed constants. Used by every file of the block; depends on nothing.
package rgbcc_pkg;

  localparam int NumRefs = 6;
  localparam int IdxW    = 3;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CfgRef0    = 3'd0,
    CfgRef1    = 3'd1,
    CfgRef2    = 3'd2,
    CfgRef3    = 3'd3,
    CfgRef4    = 3'd4,
    CfgRef5    = 3'd5,
    CfgTolStep = 3'd6,
    CfgMaxTol  = 3'd7
  } cfg_idx_e;

  localparam logic [7:0] TolStepReset = 8'd5;
  localparam logic [7:0] MaxTolReset  = 8'd50;

  // One reference color, each channel unsigned 8.8, red in the top bits.
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } ref_color_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] color_index;
    logic            found;
    logic [7:0]      tolerance_used;
  } out_item_t;

endpackage

// ===== rtl/rgbcc_match.sv =====
`timescale 1ns / 1ps
// Parallel tolerance test of one round's channel totals against all
// reference colors, with a priority pick of the lowest matching index.
// Depends on rgbcc_pkg.
module rgbcc_match #(
  parameter int SamplesPerRound = 8,
  parameter int TotW            = 11
) (
  input  logic [TotW-1:0]          red_tot_i,
  input  logic [TotW-1:0]          green_tot_i,
  input  logic [TotW-1:0]          blue_tot_i,
  input  logic [7:0]               tol_i,
  input  rgbcc_pkg::ref_color_t    refs_i [rgbcc_pkg::NumRefs],
  output logic                     hit_o,
  output logic [rgbcc_pkg::IdxW-1:0] idx_o
);

  // Every scaled quantity stays below 65536 * SamplesPerRound.
  localparam int CW = 17 + $clog2(SamplesPerRound);
  localparam logic [CW-1:0] NScale = CW'(SamplesPerRound);

  logic [CW-1:0] red_sc, green_sc, blue_sc, limit;
  logic [rgbcc_pkg::NumRefs-1:0] close;

  // Distance of total*256 from ref*N, checked against tol*256*N.
  function automatic logic chan_close(input logic [CW-1:0] tot_sc,
                                      input logic [15:0]   ref88,
                                      input logic [CW-1:0] lim);
    logic [CW-1:0] ref_sc;
    logic [CW-1:0] gap;
    ref_sc = CW'(ref88) * NScale;
    gap    = (tot_sc > ref_sc) ? (tot_sc - ref_sc) : (ref_sc - tot_sc);
    return gap <= lim;
  endfunction

  assign red_sc   = CW'({red_tot_i, 8'h00});
  assign green_sc = CW'({green_tot_i, 8'h00});
  assign blue_sc  = CW'({blue_tot_i, 8'h00});
  assign limit    = CW'({tol_i, 8'h00}) * NScale;

  always_comb begin
    for (int i = 0; i < rgbcc_pkg::NumRefs; i++) begin
      close[i] = chan_close(red_sc, refs_i[i].red, limit) &&
                 chan_close(green_sc, refs_i[i].green, limit) &&
                 chan_close(blue_sc, refs_i[i].blue, limit);
    end
  end

  // Lowest index wins, so scan from the top down.
  always_comb begin
    idx_o = '0;
    for (int i = rgbcc_pkg::NumRefs - 1; i >= 0; i--) begin
      if (close[i]) begin
        idx_o = rgbcc_pkg::IdxW'(i);
      end
    end
  end

  assign hit_o = |close;

endmodule

// ===== rtl/rgb_color_classifier_unit.sv =====
`timescale 1ns / 1ps
// RGB color classifier top level: sample accumulation, round control and
// output register. Depends on rgbcc_pkg and rgbcc_match.
//
// Usage: each input item is one 8-bit RGB sensor sample. Samples are summed
// per channel over rounds of SAMPLES_PER_ROUND items. At the end of a round
// the totals are tested against six reference colors with the current
// per-channel tolerance. A match gives a result item with found set; a
// round without a match grows the tolerance by tolerance_step, and once the
// tolerance would reach max_tolerance an invalid result item is given. In
// both cases the tolerance returns to zero. Other rounds give no item.
// Input side: an item is taken on every cycle where in_valid_i is high and
// in_stall_o is low, so one sample per cycle is sustained. The last sample
// of a round moves the totals into a round register; the comparison runs
// from there once the output register is free or draining, and a round that
// gives a result item writes it into the output register, which drives
// out_valid_o and out_item_o.
// Output side: out_valid_o and out_item_o hold while out_stall_i is high.
// A finished round waits in the round register while the output register
// is stalled full; only then is in_stall_o raised.
// Reset clears the totals, sample count, tolerance and both valid flags;
// the references reset to zero, the step to 5 and the maximum to 50.
// Configuration writes are always taken (cfg_ready_o is tied high).
module rgb_color_classifier_unit #(
  parameter int SAMPLES_PER_ROUND = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rgbcc_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rgbcc_pkg::out_item_t out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  rgbcc_pkg::cfg_idx_e  cfg_index_i,
  input  logic [47:0]          cfg_data_i
);

  // A round total holds up to 255 * SAMPLES_PER_ROUND.
  localparam int TotW = $clog2(255 * SAMPLES_PER_ROUND + 1);
  localparam int CntW = (SAMPLES_PER_ROUND > 1) ? $clog2(SAMPLES_PER_ROUND) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(SAMPLES_PER_ROUND - 1);

  // Configuration registers.
  rgbcc_pkg::ref_color_t refs_q [rgbcc_pkg::NumRefs];
  logic [7:0] step_q, max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rgbcc_pkg::NumRefs; i++) begin
        refs_q[i] <= '0;
      end
      step_q <= rgbcc_pkg::TolStepReset;
      max_q  <= rgbcc_pkg::MaxTolReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rgbcc_pkg::CfgRef0, rgbcc_pkg::CfgRef1, rgbcc_pkg::CfgRef2,
        rgbcc_pkg::CfgRef3, rgbcc_pkg::CfgRef4, rgbcc_pkg::CfgRef5: begin
          refs_q[cfg_index_i] <= cfg_data_i;
        end
        rgbcc_pkg::CfgTolStep: begin
          step_q <= cfg_data_i[7:0];
        end
        rgbcc_pkg::CfgMaxTol: begin
          max_q <= cfg_data_i[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Accumulation stage.
  logic [TotW-1:0] red_tot_q, green_tot_q, blue_tot_q;
  logic [TotW-1:0] red_add, green_add, blue_add;
  logic [CntW-1:0] cnt_q;
  logic            in_fire, last_sample;

  // Round register: totals of a finished round waiting for comparison.
  logic            rnd_vld_q, rnd_vld_d;
  logic [TotW-1:0] rnd_red_q, rnd_green_q, rnd_blue_q;

  // Comparison stage.
  logic            cmp_fire;
  logic [7:0]      tol_q, tol_d;
  logic [8:0]      tol_next;
  logic            tol_ok, give_up, hit, raw_hit, emit;
  logic [rgbcc_pkg::IdxW-1:0] hit_idx;

  logic                 out_vld_q, out_vld_d;
  rgbcc_pkg::out_item_t out_item_q;

  // The comparison runs when the output register is free or draining.
  assign cmp_fire   = rnd_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = rnd_vld_q && !cmp_fire;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign last_sample = (cnt_q == LastCnt);

  assign red_add   = red_tot_q + TotW'(in_item_i.red);
  assign green_add = green_tot_q + TotW'(in_item_i.green);
  assign blue_add  = blue_tot_q + TotW'(in_item_i.blue);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_tot_q   <= '0;
      green_tot_q <= '0;
      blue_tot_q  <= '0;
      cnt_q       <= '0;
    end else if (in_fire) begin
      if (last_sample) begin
        red_tot_q   <= '0;
        green_tot_q <= '0;
        blue_tot_q  <= '0;
        cnt_q       <= '0;
      end else begin
        red_tot_q   <= red_add;
        green_tot_q <= green_add;
        blue_tot_q  <= blue_add;
        cnt_q       <= cnt_q + CntW'(1);
      end
    end
  end

  always_comb begin
    rnd_vld_d = rnd_vld_q;
    if (cmp_fire) begin
      rnd_vld_d = 1'b0;
    end
    if (in_fire && last_sample) begin
      rnd_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_vld_q <= 1'b0;
    end else begin
      rnd_vld_q <= rnd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_sample) begin
      rnd_red_q   <= red_add;
      rnd_green_q <= green_add;
      rnd_blue_q  <= blue_add;
    end
  end

  rgbcc_match #(
    .SamplesPerRound(SAMPLES_PER_ROUND),
    .TotW           (TotW)
  ) u_match (
    .red_tot_i  (rnd_red_q),
    .green_tot_i(rnd_green_q),
    .blue_tot_i (rnd_blue_q),
    .tol_i      (tol_q),
    .refs_i     (refs_q),
    .hit_o      (raw_hit),
    .idx_o      (hit_idx)
  );

  // A round is only compared while the tolerance is below the maximum.
  // The search gives up when tol_ok fails or the grown tolerance would reach the maximum.
  assign tol_ok   = tol_q < max_q;
  assign hit      = tol_ok && raw_hit;
  assign tol_next = {1'b0, tol_q} + {1'b0, step_q};
  assign give_up  = !tol_ok || (tol_next >= {1'b0, max_q});
  assign emit     = cmp_fire && (hit || give_up);

  always_comb begin
    tol_d = tol_q;
    if (cmp_fire) begin
      tol_d = (hit || give_up) ? 8'd0 : tol_next[7:0];
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      tol_q     <= tol_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_q.color_index    <= hit ? hit_idx : '0;
      out_item_q.found          <= hit;
      out_item_q.tolerance_used <= tol_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/rgbcc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the RGB color classifier, bound to the top level.
// Depends on rgbcc_pkg and rgb_color_classifier_unit.
module rgbcc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_stall_i,
  input rgbcc_pkg::out_item_t out_item_i
);

  // A stalled result item stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // A stalled result item does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_item_i))
    else $error("result item changed while stalled");

  // An invalid result always reports color index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.found |-> out_item_i.color_index == '0)
    else $error("invalid result with nonzero color index");

  // A found result names one of the six references.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.found |->
      out_item_i.color_index < rgbcc_pkg::IdxW'(rgbcc_pkg::NumRefs))
    else $error("found result with index beyond the references");

endmodule

bind rgb_color_classifier_unit rgbcc_checker u_rgbcc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_i (out_item_o)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rgb_color_classifier_unit: predicts each round
// result from the accepted samples and checks every result item field by field.
// Depends on rgbcc_pkg and the RTL of the block; reads no file.
module tb_top;
  import rgbcc_pkg::*;

  localparam int SamplesPerRound = 8;
  localparam int LongHold        = 400;
  localparam int DrainGap        = 8;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  cfg_idx_e             cfg_index_i = CfgRef0;
  logic [47:0]          cfg_data_i  = '0;

  rgb_color_classifier_unit #(
    .SAMPLES_PER_ROUND(SamplesPerRound)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the configuration registers, at their reset values.
  ref_color_t  ref_table [NumRefs] = '{default: '0};
  logic [7:0]  tol_step = TolStepReset;
  logic [7:0]  tol_max  = MaxTolReset;

  // Predicted round state: channel sums, samples so far and the tolerance of
  // the running search, kept wide so that it never wraps.
  int red_acc      = 0;
  int green_acc    = 0;
  int blue_acc     = 0;
  int sample_count = 0;
  int search_tol   = 0;

  in_item_t  pending_samples [$];
  out_item_t expected_colors [$];

  int   mismatch_count = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic send_paused    = 1'b0;
  logic hold_go        = 1'b0;
  int   hold_left      = 0;
  int   gen_pos        = 0;  // position within a round of the next queued sample

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Exact form of |average - reference| <= tolerance, scaled by 256 * round size
  // so that the 8.8 reference needs no rounding.
  function automatic bit channel_close(input int total, input logic [15:0] level88,
                                       input int tol);
    longint diff;
    diff = longint'(total) * 256 - longint'(level88) * SamplesPerRound;
    if (diff < 0) diff = -diff;
    return diff <= longint'(tol) * 256 * SamplesPerRound;
  endfunction

  // Adds one accepted sample to the round and, at the end of a round, decides
  // between a match, a wider search, or giving up with an invalid result.
  function automatic void absorb_sample(input in_item_t s);
    int        tol;
    int        hit;
    out_item_t res;
    tol = search_tol;
    hit = -1;
    red_acc   += int'(s.red);
    green_acc += int'(s.green);
    blue_acc  += int'(s.blue);
    sample_count++;
    if (sample_count < SamplesPerRound) return;
    // The comparison is skipped when the tolerance is already at the maximum,
    // which happens when the maximum was lowered in the middle of a search.
    if (tol < int'(tol_max)) begin
      for (int i = 0; i < NumRefs && hit < 0; i++) begin
        if (channel_close(red_acc, ref_table[i].red, tol) &&
            channel_close(green_acc, ref_table[i].green, tol) &&
            channel_close(blue_acc, ref_table[i].blue, tol)) begin
          hit = i;
        end
      end
    end
    red_acc      = 0;
    green_acc    = 0;
    blue_acc     = 0;
    sample_count = 0;
    if (hit >= 0) begin
      res.color_index    = hit[IdxW-1:0];
      res.found          = 1'b1;
      res.tolerance_used = tol[7:0];
      expected_colors.push_back(res);
      search_tol = 0;
    end else if (tol >= int'(tol_max) || tol + int'(tol_step) >= int'(tol_max)) begin
      res.color_index    = '0;
      res.found          = 1'b0;
      res.tolerance_used = tol[7:0];
      expected_colors.push_back(res);
      search_tol = 0;
    end else begin
      search_tol = tol + int'(tol_step);
    end
  endfunction

  // Sample driver: a new item is offered only once the previous one has been
  // taken, so valid never follows the stall and a stalled item stays put.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) absorb_sample(in_item_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_samples.size() > 0 && !send_paused &&
            $urandom_range(99) >= send_idle_pct) begin
          in_item_i  <= pending_samples.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls, or one long hold-off when requested so
  // that the block backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else if (hold_go) begin
      hold_left   <= LongHold;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result monitor: every accepted result is checked against the oldest
  // prediction.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_colors.size() == 0) begin
        report_mismatch("unexpected result (found)", out_item_o.found, 0);
      end else begin
        want = expected_colors.pop_front();
        if (out_item_o.color_index !== want.color_index)
          report_mismatch("color_index", out_item_o.color_index, want.color_index);
        if (out_item_o.found !== want.found)
          report_mismatch("found", out_item_o.found, want.found);
        if (out_item_o.tolerance_used !== want.tolerance_used)
          report_mismatch("tolerance_used", out_item_o.tolerance_used,
                          want.tolerance_used);
      end
    end
  end

  // Must be called right after a rising edge; leaves cfg_valid_i high so that
  // writes can follow back to back.
  task automatic write_reg(input cfg_idx_e idx, input logic [47:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= CfgRef5) ref_table[int'(idx)] = value;
    else if (idx == CfgTolStep) tol_step = value[7:0];
    else tol_max = value[7:0];
  endtask

  function automatic logic [15:0] random_level();
    logic [15:0] lv;
    int          pick;
    pick = $urandom_range(9);
    lv   = 16'($urandom);
    if (pick == 0) lv = 16'h0000;
    else if (pick == 1) lv = 16'hFFFF;
    else if (pick < 5) lv[7:0] = 8'h00;  // whole levels allow exact hits
    return lv;
  endfunction

  task automatic program_settings(input int step, input int maxt);
    for (int i = 0; i < NumRefs; i++)
      write_reg(cfg_idx_e'(i), {random_level(), random_level(), random_level()});
    write_reg(CfgTolStep, 48'(step));
    write_reg(CfgMaxTol, 48'(maxt));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] near_channel(input logic [15:0] level88, input int off,
                                              input int jit);
    int v;
    v = int'(level88[15:8]) + off + int'($urandom_range(2 * jit)) - jit;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic in_item_t random_sample();
    in_item_t s;
    s.red   = 8'($urandom_range(255));
    s.green = 8'($urandom_range(255));
    s.blue  = 8'($urandom_range(255));
    return s;
  endfunction

  function automatic int random_offset();
    int mag;
    case ($urandom_range(3))
      0:       mag = 0;
      1:       mag = $urandom_range(8);
      2:       mag = $urandom_range(3) * int'(tol_step) + $urandom_range(1);
      default: mag = $urandom_range(60);
    endcase
    return $urandom_range(1) ? mag : -mag;
  endfunction

  function automatic void queue_sample(input in_item_t s);
    pending_samples.push_back(s);
    gen_pos = (gen_pos + 1) % SamplesPerRound;
  endfunction

  // Mostly rounds aimed at one reference with a chosen offset per channel, so
  // that searches widen and hit at the tolerance boundaries; the rest are
  // random rounds and stray samples that break the round alignment.
  task automatic queue_samples(input int count);
    int         pick;
    int         roff, goff, boff, jit, reps;
    ref_color_t tgt;
    while (count > 0) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        queue_sample(random_sample());
        count--;
      end else if (pick < 22) begin
        do begin
          queue_sample(random_sample());
          count--;
        end while (gen_pos != 0);
      end else begin
        tgt  = ref_table[$urandom_range(NumRefs - 1)];
        roff = random_offset();
        goff = random_offset();
        boff = random_offset();
        jit  = $urandom_range(2);
        reps = $urandom_range(1, 4);
        repeat (reps) begin
          do begin
            queue_sample('{red:   near_channel(tgt.red, roff, jit),
                           green: near_channel(tgt.green, goff, jit),
                           blue:  near_channel(tgt.blue, boff, jit)});
            count--;
          end while (gen_pos != 0);
        end
      end
    end
  endtask

  task automatic queue_const(input in_item_t s, input int n);
    repeat (n) queue_sample(s);
  endtask

  // Waits until every queued item has been taken and every predicted result
  // has arrived, then lets the round and output registers settle.
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid_i || expected_colors.size() > 0)
      @(posedge clk_i);
    repeat (DrainGap) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int steps [8];
    int maxes [8];
    int items [8];
    int step, maxt, mode;

    steps = '{1, 255, 5, 0, 1, 255, -1, 3};
    maxes = '{255, 255, 50, 50, 1, 0, -1, 20};
    items = '{200, 200, 200, 120, 200, 200, 200, 200};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset settings (all references black).
    // Saturated samples find nothing at tolerance 0, and a mixed round finds
    // nothing at tolerance 5, so the search widens twice.
    queue_const('{red: 8'hFF, green: 8'hFF, blue: 8'hFF}, SamplesPerRound);
    queue_const('{red: 8'hFF, green: 8'h00, blue: 8'hAA}, SamplesPerRound);
    drain();
    // Lowering the maximum below the running tolerance makes the next round
    // give up without comparing, even though black would match reference 0.
    write_reg(CfgMaxTol, 48'd7);
    write_reg(CfgTolStep, 48'd0);
    write_reg(CfgRef3, 48'h8000_8000_8000);
    cfg_valid_i <= 1'b0;
    queue_const('{red: 8'h00, green: 8'h00, blue: 8'h00}, SamplesPerRound);
    // Mid gray then matches reference 3 at tolerance 0 with a zero step.
    queue_const('{red: 8'h80, green: 8'h80, blue: 8'h80}, SamplesPerRound);
    drain();

    for (int p = 0; p < 8; p++) begin
      step = (steps[p] < 0) ? $urandom_range(1, 255) : steps[p];
      maxt = (maxes[p] < 0) ? $urandom_range(1, 255) : maxes[p];
      program_settings(step, maxt);
      mode = p % 4;
      send_idle_pct  <= (mode == 1) ? 60 : (mode == 3) ? 18 : 0;
      recv_stall_pct <= (mode == 2) ? 60 : (mode == 3) ? 18 : 0;
      if (p == 4) begin
        // With a maximum of 1 every round gives a result; a long receiver
        // hold-off while samples keep coming fills the block up.
        hold_go <= 1'b1;
        @(posedge clk_i);
        hold_go <= 1'b0;
        queue_samples(items[p]);
        while (pending_samples.size() > items[p] / 2) @(posedge clk_i);
        // Sender holds back until everything predicted so far has come out.
        send_paused <= 1'b1;
        while (in_valid_i || expected_colors.size() > 0) @(posedge clk_i);
        repeat (DrainGap) @(posedge clk_i);
        send_paused <= 1'b0;
      end else begin
        queue_samples(items[p]);
      end
      drain();
    end

    if (expected_colors.size() != 0)
      report_mismatch("results never delivered", 0, expected_colors.size());
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rgbcc_pkg.sv
rtl/rgbcc_match.sv
rtl/rgb_color_classifier_unit.sv
rtl/rgbcc_checker.sv
tb/sv/tb_top.sv
